>>> rtl/grouped_conv2d_point_macros.svh
// assertion helpers shared by the checker
`ifndef GROUPED_CONV2D_POINT_MACROS_SVH
`define GROUPED_CONV2D_POINT_MACROS_SVH

// same-cycle implication
`define GCP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("grouped_conv2d_point check failed");

// next-cycle implication
`define GCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("grouped_conv2d_point check failed");

`endif

>>> rtl/gcp_pkg.sv
`default_nettype none
package gcp_pkg;

  typedef enum logic [1:0] {
    REQ_ACT   = 2'd0,
    REQ_WT    = 2'd1,
    REQ_BIAS  = 2'd2,
    REQ_POINT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_GROUPS  = 3'd2,
    REG_IN_H    = 3'd3,
    REG_IN_W    = 3'd4,
    REG_KERNEL  = 3'd5,
    REG_STRIDE  = 3'd6,
    REG_PADDING = 3'd7
  } cfg_reg_t;

  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_SIDE         = 32;
  localparam int DEF_MAX_KERNEL       = 7;

  localparam int STORE_AW    = 14;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int BIAS_AW     = 4;
  localparam int BIAS_DEPTH  = 1 << BIAS_AW;

  localparam logic [31:0] FP_QNAN  = 32'hFFC0_0000;
  localparam logic [31:0] FP_QBIT  = 32'h0040_0000;

  // leading zero count of the 50-bit rounding word
  function automatic logic [5:0] lzc50(input logic [49:0] m);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (m[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/grouped_conv2d_point.sv
// load items: taken while idle and written to their store (bias index past 15 dropped), no result
// compute point: setup divides channel counts by the groups, checks the point, finds its
// group and forms base indices; a padding tap is skipped, a live tap is read, multiplied,
// rounded, aligned, added and rounded through one shared float datapath
// one point at a time; a pending result does not block the next input transfer
// rst_n is synchronous: registers back to their reset values, bias store cleared
`default_nettype none
module grouped_conv2d_point
  import gcp_pkg::*;
#(
  parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
  parameter int MAX_SIDE         = DEF_MAX_SIDE,
  parameter int MAX_KERNEL       = DEF_MAX_KERNEL
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [13:0] in_index,
  input  wire logic [31:0] in_value,
  input  wire logic [3:0]  in_out_channel,
  input  wire logic [5:0]  in_out_row,
  input  wire logic [5:0]  in_out_col,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_bits,
  output logic             out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV_CIN, ST_DIV_COUT, ST_CHK, ST_CHK2, ST_DIV_G,
    ST_BASE1, ST_BASE2, ST_BASE3, ST_ADDR, ST_ADDR2, ST_RD, ST_MUL,
    ST_LZ_P, ST_RND_P, ST_AL, ST_SUM, ST_LZ_S, ST_RND_S, ST_OUT
  } state_t;

  localparam int DIV_W = 5;
  localparam logic [2:0] DIV_LAST = 3'(DIV_W - 1);

  // configuration registers
  logic [4:0] cfg_in_ch_r, cfg_out_ch_r, cfg_groups_r;
  logic [5:0] cfg_in_h_r, cfg_in_w_r;
  logic [7:0] cfg_kernel_r, cfg_stride_r, cfg_padding_r;

  state_t state_r;
  logic   in_acc, cfg_wr;

  logic [31:0] act_mem [STORE_DEPTH];
  logic [31:0] wt_mem  [STORE_DEPTH];
  logic [31:0] bias_r  [BIAS_DEPTH];
  logic [31:0] act_q_r, wt_q_r;

  // clamped shape at transfer time
  logic [4:0] cin_c, cout_c, grp_c;
  logic [5:0] h_c, w_c;
  logic [3:0] kh_c, kw_c, sh_c, sw_c;

  logic [3:0] co_r;
  logic [5:0] oh_r, ow_r;
  logic [4:0] cout_r, grp_r;
  logic [5:0] h_r, w_r;
  logic [3:0] kh_r, kw_r, sh_r, sw_r, ph_r, pw_r;
  logic [4:0] cin_pg_r, cout_pg_r, g_r;
  logic [9:0] gc_r, ohs_r, ows_r;
  logic signed [8:0] numh_r, numw_r;
  logic [9:0] cibase_r;
  logic [8:0] wt1_r;
  logic [12:0] wt2_r;
  logic signed [11:0] ih0_r, iw0_r;
  logic [13:0] wi_r, ai_r;
  logic [15:0] t1_r;
  logic [5:0] iw_r;
  logic [4:0] cl_r;
  logic [3:0] kr_r, kc_r;
  logic [31:0] acc_r, prod_r, res_r;
  logic        stat_r;
  logic        out_valid_r, out_status_r;
  logic [31:0] out_result_bits_r;

  // shared small divider
  logic [4:0] div_n_r, div_d_r, div_q_r, div_rem_r;
  logic [2:0] div_cnt_r;
  logic [5:0] div_t;
  logic       div_ge;
  logic [4:0] div_rem_nxt, div_q_nxt, div_n_nxt;

  // rounding unit operands
  logic [49:0] rnd_m_r;
  logic signed [10:0] rnd_e_r;
  logic        rnd_s_r, rnd_zs_r, rnd_spec_r;
  logic [31:0] rnd_sval_r;
  logic [5:0]  lz_r;

  // add alignment registers
  logic [47:0] ad_big_r, ad_small_r;
  logic        ad_sub_r, ad_s_r, ad_zs_r, ad_spec_r;
  logic [7:0]  ad_e_r;
  logic [31:0] ad_sval_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_bits_r;
  assign out_status      = out_status_r;

  // ---------------- configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_ch_r   <= 5'd1;
      cfg_out_ch_r  <= 5'd1;
      cfg_groups_r  <= 5'd1;
      cfg_in_h_r    <= 6'd32;
      cfg_in_w_r    <= 6'd32;
      cfg_kernel_r  <= 8'h33;
      cfg_stride_r  <= 8'h11;
      cfg_padding_r <= 8'h00;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[4:2]))
        REG_IN_CH:   cfg_in_ch_r   <= pwdata[4:0];
        REG_OUT_CH:  cfg_out_ch_r  <= pwdata[4:0];
        REG_GROUPS:  cfg_groups_r  <= pwdata[4:0];
        REG_IN_H:    cfg_in_h_r    <= pwdata[5:0];
        REG_IN_W:    cfg_in_w_r    <= pwdata[5:0];
        REG_KERNEL:  cfg_kernel_r  <= pwdata[7:0];
        REG_STRIDE:  cfg_stride_r  <= pwdata[7:0];
        REG_PADDING: cfg_padding_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    prdata = 32'h0;
    unique case (cfg_reg_t'(paddr[4:2]))
      REG_IN_CH:   prdata = {27'h0, cfg_in_ch_r};
      REG_OUT_CH:  prdata = {27'h0, cfg_out_ch_r};
      REG_GROUPS:  prdata = {27'h0, cfg_groups_r};
      REG_IN_H:    prdata = {26'h0, cfg_in_h_r};
      REG_IN_W:    prdata = {26'h0, cfg_in_w_r};
      REG_KERNEL:  prdata = {24'h0, cfg_kernel_r};
      REG_STRIDE:  prdata = {24'h0, cfg_stride_r};
      REG_PADDING: prdata = {24'h0, cfg_padding_r};
    endcase
  end

  // ---------------- clamping
  always_comb begin
    if (cfg_in_ch_r == 5'd0) cin_c = 5'd1;
    else if (32'(cfg_in_ch_r) > MAX_IN_CHANNELS) cin_c = 5'(MAX_IN_CHANNELS);
    else cin_c = cfg_in_ch_r;
    if (cfg_out_ch_r == 5'd0) cout_c = 5'd1;
    else if (32'(cfg_out_ch_r) > MAX_OUT_CHANNELS) cout_c = 5'(MAX_OUT_CHANNELS);
    else cout_c = cfg_out_ch_r;
    grp_c = (cfg_groups_r == 5'd0) ? 5'd1 : cfg_groups_r;
    if (cfg_in_h_r == 6'd0) h_c = 6'd1;
    else if (32'(cfg_in_h_r) > MAX_SIDE) h_c = 6'(MAX_SIDE);
    else h_c = cfg_in_h_r;
    if (cfg_in_w_r == 6'd0) w_c = 6'd1;
    else if (32'(cfg_in_w_r) > MAX_SIDE) w_c = 6'(MAX_SIDE);
    else w_c = cfg_in_w_r;
    if (cfg_kernel_r[7:4] == 4'd0) kh_c = 4'd1;
    else if (32'(cfg_kernel_r[7:4]) > MAX_KERNEL) kh_c = 4'(MAX_KERNEL);
    else kh_c = cfg_kernel_r[7:4];
    if (cfg_kernel_r[3:0] == 4'd0) kw_c = 4'd1;
    else if (32'(cfg_kernel_r[3:0]) > MAX_KERNEL) kw_c = 4'(MAX_KERNEL);
    else kw_c = cfg_kernel_r[3:0];
    sh_c = (cfg_stride_r[7:4] == 4'd0) ? 4'd1 : cfg_stride_r[7:4];
    sw_c = (cfg_stride_r[3:0] == 4'd0) ? 4'd1 : cfg_stride_r[3:0];
  end

  // ---------------- stores
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == REQ_ACT) act_mem[in_index] <= in_value;
    if (state_r == ST_RD) act_q_r <= act_mem[ai_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == REQ_WT) wt_mem[in_index] <= in_value;
    if (state_r == ST_RD) wt_q_r <= wt_mem[wi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BIAS_DEPTH; i++) bias_r[i] <= 32'h0;
    end else if (in_acc && in_req_type == REQ_BIAS && in_index < 14'(BIAS_DEPTH)) begin
      bias_r[in_index[BIAS_AW-1:0]] <= in_value;
    end
  end

  // ---------------- divider step, one quotient bit a cycle
  always_comb begin
    div_t       = {div_rem_r, div_n_r[DIV_W-1]};
    div_ge      = (div_t >= {1'b0, div_d_r});
    div_rem_nxt = div_ge ? 5'(div_t - {1'b0, div_d_r}) : div_t[4:0];
    div_q_nxt   = {div_q_r[3:0], div_ge};
    div_n_nxt   = {div_n_r[3:0], 1'b0};
  end

  // ---------------- point setup products
  logic [9:0]  gc_c, ohs_c, ows_c;
  logic signed [8:0] numh_c, numw_c;
  logic [8:0]  wt1_c;
  logic [9:0]  cibase_c;
  logic [12:0] wt2_c;
  logic [16:0] wt3_c;
  logic        bad_c;

  always_comb begin
    gc_c     = grp_r * cout_pg_r;
    ohs_c    = oh_r * sh_r;
    ows_c    = ow_r * sw_r;
    numh_c   = $signed({3'b0, h_r}) + $signed({4'b0, ph_r, 1'b0}) - $signed({5'b0, kh_r});
    numw_c   = $signed({3'b0, w_r}) + $signed({4'b0, pw_r, 1'b0}) - $signed({5'b0, kw_r});
    wt1_c    = co_r * cin_pg_r;
    cibase_c = g_r * cin_pg_r;
    wt2_c    = wt1_r * kh_r;
    wt3_c    = wt2_r * kw_r;
    bad_c    = ({1'b0, co_r} >= cout_r) || (cout_pg_r == 5'd0) ||
               ({6'b0, co_r} >= gc_r) ||
               numh_r[8] || (ohs_r > {1'b0, numh_r}) ||
               numw_r[8] || (ows_r > {1'b0, numw_r});
  end

  // ---------------- tap addressing
  logic signed [11:0] ih_c, iw_c;
  logic        inb_c;
  logic [9:0]  ci_c;
  logic [15:0] t1_c;
  logic [21:0] ai_c;
  logic [3:0]  kc_nxt, kr_nxt;
  logic [4:0]  cl_nxt;
  logic        tap_last;

  always_comb begin
    ih_c  = ih0_r + $signed({8'b0, kr_r});
    iw_c  = iw0_r + $signed({8'b0, kc_r});
    inb_c = !ih_c[11] && (ih_c < $signed({6'b0, h_r})) &&
            !iw_c[11] && (iw_c < $signed({6'b0, w_r}));
    ci_c  = cibase_r + {5'b0, cl_r};
    t1_c  = ci_c * h_r + {10'b0, ih_c[5:0]};
    ai_c  = t1_r * w_r + {16'b0, iw_r};
    kc_nxt = kc_r + 4'd1;
    kr_nxt = kr_r;
    cl_nxt = cl_r;
    if (kc_r == kw_r - 4'd1) begin
      kc_nxt = 4'd0;
      kr_nxt = kr_r + 4'd1;
      if (kr_r == kh_r - 4'd1) begin
        kr_nxt = 4'd0;
        cl_nxt = cl_r + 5'd1;
      end
    end
    tap_last = (kc_r == kw_r - 4'd1) && (kr_r == kh_r - 4'd1) &&
               (cl_r == cin_pg_r - 5'd1);
  end

  // ---------------- float multiply front end
  logic [7:0]  mu_ea, mu_eb, mu_eav, mu_ebv;
  logic [23:0] mu_ma, mu_mb;
  logic [47:0] mu_p;
  logic signed [10:0] mu_e;
  logic        mu_s, mu_an, mu_bn, mu_ai, mu_bi, mu_az, mu_bz, mu_spec;
  logic [31:0] mu_sval;

  always_comb begin
    mu_ea  = act_q_r[30:23];
    mu_eb  = wt_q_r[30:23];
    mu_eav = (mu_ea == 8'd0) ? 8'd1 : mu_ea;
    mu_ebv = (mu_eb == 8'd0) ? 8'd1 : mu_eb;
    mu_ma  = {|mu_ea, act_q_r[22:0]};
    mu_mb  = {|mu_eb, wt_q_r[22:0]};
    mu_p   = mu_ma * mu_mb;
    mu_e   = $signed({3'b0, mu_eav}) + $signed({3'b0, mu_ebv}) - 11'sd126;
    mu_s   = act_q_r[31] ^ wt_q_r[31];
    mu_an  = (mu_ea == 8'hFF) && (act_q_r[22:0] != 23'd0);
    mu_bn  = (mu_eb == 8'hFF) && (wt_q_r[22:0] != 23'd0);
    mu_ai  = (mu_ea == 8'hFF) && (act_q_r[22:0] == 23'd0);
    mu_bi  = (mu_eb == 8'hFF) && (wt_q_r[22:0] == 23'd0);
    mu_az  = (act_q_r[30:0] == 31'd0);
    mu_bz  = (wt_q_r[30:0] == 31'd0);
    mu_spec = 1'b1;
    if (mu_an) mu_sval = act_q_r | FP_QBIT;
    else if (mu_bn) mu_sval = wt_q_r | FP_QBIT;
    else if ((mu_ai && mu_bz) || (mu_bi && mu_az)) mu_sval = FP_QNAN;
    else if (mu_ai || mu_bi) mu_sval = {mu_s, 8'hFF, 23'd0};
    else if (mu_az || mu_bz) mu_sval = {mu_s, 31'd0};
    else begin
      mu_spec = 1'b0;
      mu_sval = 32'h0;
    end
  end

  // ---------------- float add alignment, acc + prod
  logic        al_swap, al_an, al_bn, al_ai, al_bi, al_spec;
  logic [31:0] al_big, al_small, al_sval;
  logic [7:0]  al_ebv, al_esv, al_d;
  logic [5:0]  al_sh;
  logic [95:0] al_wide;
  logic [47:0] al_small_sh;

  always_comb begin
    al_swap  = (prod_r[30:0] > acc_r[30:0]);
    al_big   = al_swap ? prod_r : acc_r;
    al_small = al_swap ? acc_r : prod_r;
    al_ebv   = (al_big[30:23] == 8'd0) ? 8'd1 : al_big[30:23];
    al_esv   = (al_small[30:23] == 8'd0) ? 8'd1 : al_small[30:23];
    al_d     = al_ebv - al_esv;
    al_sh    = (al_d > 8'd63) ? 6'd63 : al_d[5:0];
    al_wide  = {|al_small[30:23], al_small[22:0], 72'd0} >> al_sh;
    al_small_sh = al_wide[95:48] | {47'd0, |al_wide[47:0]};
    al_an = (acc_r[30:23] == 8'hFF) && (acc_r[22:0] != 23'd0);
    al_bn = (prod_r[30:23] == 8'hFF) && (prod_r[22:0] != 23'd0);
    al_ai = (acc_r[30:0] == 31'h7F80_0000);
    al_bi = (prod_r[30:0] == 31'h7F80_0000);
    al_spec = 1'b1;
    if (al_an) al_sval = acc_r | FP_QBIT;
    else if (al_bn) al_sval = prod_r | FP_QBIT;
    else if (al_ai && al_bi && (acc_r[31] != prod_r[31])) al_sval = FP_QNAN;
    else if (al_ai) al_sval = acc_r;
    else if (al_bi) al_sval = prod_r;
    else begin
      al_spec = 1'b0;
      al_sval = 32'h0;
    end
  end

  // ---------------- shared normalize and round
  logic [5:0]  lz_c;
  logic signed [11:0] rn_e, rn_enorm, rn_eeff, rn_r, rn_ex;
  logic [5:0]  rn_lsh, rn_rsh;
  logic [99:0] rn_wide;
  logic [49:0] rn_n;
  logic        rn_sticky, rn_g, rn_st;
  logic [24:0] rn_sig, rn_sig2;
  logic signed [11:0] rn_expf;
  logic [31:0] rnd_res;

  always_comb begin
    lz_c     = lzc50(rnd_m_r);
    rn_e     = {rnd_e_r[10], rnd_e_r};
    rn_enorm = rn_e + 12'sd2 - $signed({6'b0, lz_r});
    rn_eeff  = (rn_enorm < 12'sd1) ? 12'sd1 : rn_enorm;
    rn_r     = rn_eeff - rn_e;
    rn_lsh   = 6'(-rn_r);
    rn_rsh   = (rn_r > 12'sd63) ? 6'd63 : rn_r[5:0];
    rn_wide  = {rnd_m_r, 50'd0} >> rn_rsh;
    if (rn_r < 12'sd0) begin
      rn_n      = rnd_m_r << rn_lsh;
      rn_sticky = 1'b0;
    end else begin
      rn_n      = rn_wide[99:50];
      rn_sticky = |rn_wide[49:0];
    end
    rn_g   = rn_n[23];
    rn_st  = (|rn_n[22:0]) | rn_sticky;
    rn_sig = {1'b0, rn_n[47:24]} + {24'd0, rn_g & (rn_st | rn_n[24])};
    if (rn_sig[24]) begin
      rn_sig2 = rn_sig >> 1;
      rn_ex   = rn_eeff + 12'sd1;
    end else begin
      rn_sig2 = rn_sig;
      rn_ex   = rn_eeff;
    end
    rn_expf = rn_sig2[23] ? rn_ex : 12'sd0;
    if (rnd_spec_r) rnd_res = rnd_sval_r;
    else if (rnd_m_r == 50'd0) rnd_res = {rnd_zs_r, 31'd0};
    else if (rn_expf >= 12'sd255) rnd_res = {rnd_s_r, 8'hFF, 23'd0};
    else rnd_res = {rnd_s_r, rn_expf[7:0], rn_sig2[22:0]};
  end

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_req_type == REQ_POINT) begin
            co_r   <= in_out_channel;
            oh_r   <= in_out_row;
            ow_r   <= in_out_col;
            cout_r <= cout_c;
            grp_r  <= grp_c;
            h_r    <= h_c;
            w_r    <= w_c;
            kh_r   <= kh_c;
            kw_r   <= kw_c;
            sh_r   <= sh_c;
            sw_r   <= sw_c;
            ph_r   <= cfg_padding_r[7:4];
            pw_r   <= cfg_padding_r[3:0];
            div_n_r   <= cin_c;
            div_d_r   <= grp_c;
            div_rem_r <= 5'd0;
            div_q_r   <= 5'd0;
            div_cnt_r <= 3'd0;
            state_r   <= ST_DIV_CIN;
          end
        end
        ST_DIV_CIN, ST_DIV_COUT, ST_DIV_G: begin
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_n_r   <= div_n_nxt;
          div_cnt_r <= div_cnt_r + 3'd1;
          if (div_cnt_r == DIV_LAST) begin
            div_rem_r <= 5'd0;
            div_q_r   <= 5'd0;
            div_cnt_r <= 3'd0;
            if (state_r == ST_DIV_CIN) begin
              cin_pg_r <= div_q_nxt;
              div_n_r  <= cout_r;
              div_d_r  <= grp_r;
              state_r  <= ST_DIV_COUT;
            end else if (state_r == ST_DIV_COUT) begin
              cout_pg_r <= div_q_nxt;
              state_r   <= ST_CHK;
            end else begin
              g_r     <= div_q_nxt;
              state_r <= ST_BASE1;
            end
          end
        end
        ST_CHK: begin
          gc_r    <= gc_c;
          ohs_r   <= ohs_c;
          ows_r   <= ows_c;
          numh_r  <= numh_c;
          numw_r  <= numw_c;
          state_r <= ST_CHK2;
        end
        ST_CHK2: begin
          if (bad_c) begin
            res_r   <= 32'h0;
            stat_r  <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            div_n_r <= {1'b0, co_r};
            div_d_r <= cout_pg_r;
            state_r <= ST_DIV_G;
          end
        end
        ST_BASE1: begin
          cibase_r <= cibase_c;
          wt1_r    <= wt1_c;
          ih0_r    <= $signed({2'b0, ohs_r}) - $signed({8'b0, ph_r});
          iw0_r    <= $signed({2'b0, ows_r}) - $signed({8'b0, pw_r});
          acc_r    <= bias_r[co_r];
          state_r  <= ST_BASE2;
        end
        ST_BASE2: begin
          wt2_r   <= wt2_c;
          cl_r    <= 5'd0;
          kr_r    <= 4'd0;
          kc_r    <= 4'd0;
          state_r <= ST_BASE3;
        end
        ST_BASE3: begin
          wi_r <= wt3_c[13:0];
          if (cin_pg_r == 5'd0) begin
            res_r   <= acc_r;
            stat_r  <= 1'b0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (inb_c) begin
            t1_r    <= t1_c;
            iw_r    <= iw_c[5:0];
            state_r <= ST_ADDR2;
          end else begin
            // tap in the padding: skip, weight index still moves
            wi_r <= wi_r + 14'd1;
            kc_r <= kc_nxt;
            kr_r <= kr_nxt;
            cl_r <= cl_nxt;
            if (tap_last) begin
              res_r   <= acc_r;
              stat_r  <= 1'b0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_ADDR2: begin
          ai_r    <= ai_c[13:0];
          state_r <= ST_RD;
        end
        ST_RD: state_r <= ST_MUL;
        ST_MUL: begin
          rnd_m_r    <= {2'b0, mu_p};
          rnd_e_r    <= mu_e;
          rnd_s_r    <= mu_s;
          rnd_zs_r   <= mu_s;
          rnd_spec_r <= mu_spec;
          rnd_sval_r <= mu_sval;
          state_r    <= ST_LZ_P;
        end
        ST_LZ_P: begin
          lz_r    <= lz_c;
          state_r <= ST_RND_P;
        end
        ST_RND_P: begin
          prod_r  <= rnd_res;
          state_r <= ST_AL;
        end
        ST_AL: begin
          ad_big_r   <= {|al_big[30:23], al_big[22:0], 24'd0};
          ad_small_r <= al_small_sh;
          ad_sub_r   <= acc_r[31] ^ prod_r[31];
          ad_s_r     <= al_big[31];
          ad_zs_r    <= acc_r[31] & prod_r[31];
          ad_e_r     <= al_ebv;
          ad_spec_r  <= al_spec;
          ad_sval_r  <= al_sval;
          state_r    <= ST_SUM;
        end
        ST_SUM: begin
          rnd_m_r    <= ad_sub_r ? ({2'b0, ad_big_r} - {2'b0, ad_small_r})
                                 : ({2'b0, ad_big_r} + {2'b0, ad_small_r});
          rnd_e_r    <= $signed({3'b0, ad_e_r});
          rnd_s_r    <= ad_s_r;
          rnd_zs_r   <= ad_zs_r;
          rnd_spec_r <= ad_spec_r;
          rnd_sval_r <= ad_sval_r;
          state_r    <= ST_LZ_S;
        end
        ST_LZ_S: begin
          lz_r    <= lz_c;
          state_r <= ST_RND_S;
        end
        ST_RND_S: begin
          acc_r <= rnd_res;
          wi_r  <= wi_r + 14'd1;
          kc_r  <= kc_nxt;
          kr_r  <= kr_nxt;
          cl_r  <= cl_nxt;
          if (tap_last) begin
            res_r   <= rnd_res;
            stat_r  <= 1'b0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_ADDR;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_result_bits_r <= res_r;
            out_status_r      <= stat_r;
            state_r           <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/grouped_conv2d_point_chk.sv
`default_nettype none
`include "grouped_conv2d_point_macros.svh"
module grouped_conv2d_point_chk
  import gcp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_req_type,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_result_bits,
  input wire logic        out_status
);

  // a compute transfer occupies the block
  `GCP_ASSERT_NEXT(a_point_busy, clk, rst_n, in_valid && !in_stall && in_req_type == REQ_POINT, in_stall)
  // loads complete in the transfer cycle
  `GCP_ASSERT_NEXT(a_load_ready, clk, rst_n, in_valid && !in_stall && in_req_type != REQ_POINT, !in_stall)
  // flagged points carry a zero word
  `GCP_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_status, out_result_bits == 32'h0)
  `GCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_bits) && $stable(out_status))

endmodule

bind grouped_conv2d_point grouped_conv2d_point_chk u_chk (.*);
`default_nettype wire

>>> dv/grouped_conv2d_point_checker.sv
`timescale 1ns / 100ps
module grouped_conv2d_point_checker
  import gcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [13:0] in_index,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_out_channel,
  input  logic [5:0]  in_out_row,
  input  logic [5:0]  in_out_col,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result_bits,
  input  logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] bits;
    logic        status;
  } point_t;

  logic [31:0] act_mem [STORE_DEPTH];
  logic [31:0] wt_mem [STORE_DEPTH];
  logic [31:0] bias_mem [BIAS_DEPTH];
  logic [7:0]  regs [8];
  point_t      expected_points [$];

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int extent(int side, int pad, int k, int s);
    int num;
    num = side + 2 * pad - k;
    if (num < 0) return 0;
    return num / s + 1;
  endfunction

  function automatic real f32_to_real(logic [31:0] b);
    real r;
    if (b[30:0] == 31'd0) return $bitstoreal({b[31], 63'd0});
    if (b[30:23] == 8'd0) begin
      r = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -r : r;
    end
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
  endfunction

  // round to nearest even; double is wide enough that rounding twice is exact
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d, sig, q, rem, half, base, mag;
    int be, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    be = int'(d[62:52]) - 896;
    sig = {11'd0, 1'b1, d[51:0]};
    if (be >= 1) begin
      sh = 29;
      base = 64'(be - 1) << 23;
    end else begin
      sh = 30 - be;
      base = 64'd0;
    end
    if (sh > 60) return {d[63], 31'd0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    mag = base + q;
    if (mag >= 64'h7F80_0000) mag = 64'h7F80_0000;
    return {d[63], mag[30:0]};
  endfunction

  function automatic point_t conv_point(int co, int oh, int ow);
    point_t p;
    int cin, cout, grp, h, w, kh, kw, sh, sw, ph, pw, hout, wout, cin_pg, cout_pg;
    int g, ci, ih, iw;
    logic [31:0] acc, prod;
    cin = clampi(regs[REG_IN_CH], 1, DEF_MAX_IN_CHANNELS);
    cout = clampi(regs[REG_OUT_CH], 1, DEF_MAX_OUT_CHANNELS);
    grp = (regs[REG_GROUPS] == 0) ? 1 : regs[REG_GROUPS];
    h = clampi(regs[REG_IN_H], 1, DEF_MAX_SIDE);
    w = clampi(regs[REG_IN_W], 1, DEF_MAX_SIDE);
    kh = clampi(regs[REG_KERNEL][7:4], 1, DEF_MAX_KERNEL);
    kw = clampi(regs[REG_KERNEL][3:0], 1, DEF_MAX_KERNEL);
    sh = (regs[REG_STRIDE][7:4] == 0) ? 1 : regs[REG_STRIDE][7:4];
    sw = (regs[REG_STRIDE][3:0] == 0) ? 1 : regs[REG_STRIDE][3:0];
    ph = regs[REG_PADDING][7:4];
    pw = regs[REG_PADDING][3:0];
    hout = extent(h, ph, kh, sh);
    wout = extent(w, pw, kw, sw);
    cin_pg = cin / grp;
    cout_pg = cout / grp;
    if (co >= cout || cout_pg == 0 || co >= grp * cout_pg || oh >= hout || ow >= wout) begin
      p.bits = 32'd0;
      p.status = 1'b1;
      return p;
    end
    g = co / cout_pg;
    acc = bias_mem[co];
    for (int cl = 0; cl < cin_pg; cl++) begin
      ci = g * cin_pg + cl;
      for (int kr = 0; kr < kh; kr++) begin
        for (int kc = 0; kc < kw; kc++) begin
          ih = oh * sh - ph + kr;
          iw = ow * sw - pw + kc;
          if (ih >= 0 && ih < h && iw >= 0 && iw < w) begin
            prod = real_to_f32(f32_to_real(act_mem[((ci * h + ih) * w + iw) & 16383]) *
                               f32_to_real(wt_mem[(((co * cin_pg + cl) * kh + kr) * kw + kc)
                                                  & 16383]));
            acc = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
          end
        end
      end
    end
    p.bits = acc;
    p.status = 1'b0;
    return p;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst_n) begin
      regs = '{8'd1, 8'd1, 8'd1, 8'd32, 8'd32, 8'h33, 8'h11, 8'h00};
      for (int i = 0; i < BIAS_DEPTH; i++) bias_mem[i] = 32'd0;
      expected_points.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:2] <= REG_PADDING) begin
        case (cfg_reg_t'(paddr[4:2]))
          REG_IN_CH, REG_OUT_CH, REG_GROUPS: regs[paddr[4:2]] = {3'd0, pwdata[4:0]};
          REG_IN_H, REG_IN_W: regs[paddr[4:2]] = {2'd0, pwdata[5:0]};
          default: regs[paddr[4:2]] = pwdata[7:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result bits=%h status=%b", $time, out_result_bits,
                   out_status);
          fail_count++;
        end else begin
          e = expected_points.pop_front();
          if (e.bits !== out_result_bits || e.status !== out_status) begin
            $display("%0t: expected bits=%h status=%b, got bits=%h status=%b", $time,
                     e.bits, e.status, out_result_bits, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (req_t'(in_req_type))
          REQ_ACT: act_mem[in_index] = in_value;
          REQ_WT: wt_mem[in_index] = in_value;
          REQ_BIAS: if (in_index < BIAS_DEPTH) bias_mem[in_index[3:0]] = in_value;
          default: expected_points.push_back(conv_point(in_out_channel, in_out_row, in_out_col));
        endcase
      end
    end
    pending = expected_points.size();
  end

endmodule

>>> dv/grouped_conv2d_point_tb.sv
`timescale 1ns / 100ps
module grouped_conv2d_point_tb;
  import gcp_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_ACT;
  logic [13:0] in_index = '0;
  logic [31:0] in_value = '0;
  logic [3:0]  in_out_channel = '0;
  logic [5:0]  in_out_row = '0;
  logic [5:0]  in_out_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_bits;
  logic        out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int items = 0;
  bit quiet = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int stall_run = 0;
  int idle_cycles = 0;

  // shape of the current setting, as the block sees it
  int e_cin, e_cout, e_grp, e_h, e_w, e_kh, e_kw, e_hout, e_wout;

  always #5 clk = ~clk;

  grouped_conv2d_point uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_index(in_index), .in_value(in_value), .in_out_channel(in_out_channel),
    .in_out_row(in_out_row), .in_out_col(in_out_col),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_bits(out_result_bits),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  grouped_conv2d_point_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_index(in_index), .in_value(in_value), .in_out_channel(in_out_channel),
    .in_out_row(in_out_row), .in_out_col(in_out_col),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_bits(out_result_bits),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grouped_conv2d_point: mismatch");
      $finish;
    end
  end

  // result side: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall = 1'b1;
          stall_run = $urandom_range(20, 60);
        end
        1, 2, 3, 4: begin
          out_stall = 1'b1;
          stall_run = $urandom_range(0, 3);
        end
        default: begin
          out_stall = 1'b0;
          stall_run = $urandom_range(0, 8);
        end
      endcase
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] rand_f32();
    case ($urandom_range(0, 19))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  task automatic send(logic [1:0] req, int idx, logic [31:0] val, int co, int oh, int ow);
    int gap;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_req_type = req;
    in_index = 14'(idx);
    in_value = val;
    in_out_channel = 4'(co);
    in_out_row = 6'(oh);
    in_out_col = 6'(ow);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    items++;
  endtask

  task automatic load(logic [1:0] req, int idx, logic [31:0] val);
    send(req, idx, val, $urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic point(int co, int oh, int ow);
    send(REQ_POINT, $urandom_range(0, 16383), $urandom, co, oh, ow);
  endtask

  task automatic reg_write(cfg_reg_t r, logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic setup(int cin, int cout, int grp, int h, int w, int k, int s, int p);
    int sh, sw, ph, pw, num;
    drain();
    reg_write(REG_IN_CH, cin);
    reg_write(REG_OUT_CH, cout);
    reg_write(REG_GROUPS, grp);
    reg_write(REG_IN_H, h);
    reg_write(REG_IN_W, w);
    reg_write(REG_KERNEL, k);
    reg_write(REG_STRIDE, s);
    reg_write(REG_PADDING, p);
    e_cin = clampi(cin & 31, 1, 16);
    e_cout = clampi(cout & 31, 1, 16);
    e_grp = ((grp & 31) == 0) ? 1 : (grp & 31);
    e_h = clampi(h & 63, 1, 32);
    e_w = clampi(w & 63, 1, 32);
    e_kh = clampi((k >> 4) & 15, 1, 7);
    e_kw = clampi(k & 15, 1, 7);
    sh = ((s >> 4) & 15) == 0 ? 1 : (s >> 4) & 15;
    sw = (s & 15) == 0 ? 1 : s & 15;
    ph = (p >> 4) & 15;
    pw = p & 15;
    num = e_h + 2 * ph - e_kh;
    e_hout = num < 0 ? 0 : num / sh + 1;
    num = e_w + 2 * pw - e_kw;
    e_wout = num < 0 ? 0 : num / sw + 1;
  endtask

  task automatic fill_stores();
    int nact, nwt;
    nact = e_cin * e_h * e_w;
    nwt = e_cout * (e_cin / e_grp) * e_kh * e_kw;
    for (int i = 0; i < nact; i++) load(REQ_ACT, i, rand_f32());
    for (int i = 0; i < nwt; i++) load(REQ_WT, i, rand_f32());
    for (int i = 0; i < e_cout; i++)
      if ($urandom_range(0, 2) != 0) load(REQ_BIAS, i, rand_f32());
    load(REQ_BIAS, $urandom_range(16, 16383), rand_f32());
  endtask

  task automatic run_points(int npts);
    int nact, nwt;
    nact = e_cin * e_h * e_w;
    nwt = e_cout * (e_cin / e_grp) * e_kh * e_kw;
    for (int n = 0; n < npts; n++) begin
      case ($urandom_range(0, 19))
        0: if (nact > 0) load(REQ_ACT, $urandom_range(0, nact - 1), rand_f32());
        1: if (nwt > 0) load(REQ_WT, $urandom_range(0, nwt - 1), rand_f32());
        2: load(REQ_BIAS, $urandom_range(0, 15), rand_f32());
        3: load($urandom_range(0, 1) == 1 ? REQ_ACT : REQ_WT, $urandom_range(8192, 16383),
                $urandom);
        default: ;
      endcase
      if ($urandom_range(0, 9) < 8)
        point($urandom_range(0, e_cout - 1), $urandom_range(0, e_hout),
              $urandom_range(0, e_wout));
      else
        point($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  task automatic phase(int cin, int cout, int grp, int h, int w, int k, int s, int p,
                       int npts);
    quiet = ($urandom_range(0, 4) == 0);
    setup(cin, cout, grp, h, w, k, s, p);
    fill_stores();
    run_points(npts);
  endtask

  initial begin
    logic [31:0] acts [9];
    logic [31:0] wts [4];
    acts = '{32'h3F80_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h007F_FFFF,
             32'h4B7F_FFFF, 32'hC120_0000, 32'h3EAA_AAAB, 32'h5F00_0000};
    wts = '{32'h3F80_0000, 32'hBF00_0000, 32'h0080_0000, 32'h3DCC_CCCD};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: 3x3 image, 2x2 kernel, padding one on each side
    quiet = 1'b1;
    setup(1, 1, 1, 3, 3, 8'h22, 8'h11, 8'h11);
    for (int i = 0; i < 9; i++) load(REQ_ACT, i, acts[i]);
    for (int i = 0; i < 4; i++) load(REQ_WT, i, wts[i]);
    load(REQ_BIAS, 0, 32'h3FC0_0000);
    load(REQ_BIAS, 16383, 32'h4000_0000);
    point(0, 0, 0);
    point(0, 3, 3);
    point(0, 1, 2);
    point(0, 4, 0);
    point(0, 0, 4);
    point(1, 0, 0);
    point(15, 63, 63);

    // register extremes and corner shapes
    phase(0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 10);
    phase(31, 31, 31, 63, 1, 8'hFF, 8'hFF, 8'hFF, 15);
    phase(16, 16, 16, 2, 2, 8'h33, 8'h11, 8'h11, 30);
    phase(2, 4, 2, 1, 32, 8'h17, 8'h12, 8'h03, 25);
    phase(1, 2, 1, 32, 1, 8'h71, 8'h31, 8'h30, 25);
    phase(1, 1, 1, 2, 2, 8'h55, 8'h11, 8'h00, 10);
    phase(2, 4, 4, 3, 3, 8'h22, 8'h11, 8'h00, 15);
    phase(4, 5, 2, 3, 3, 8'h22, 8'h21, 8'h01, 25);

    // long hold-off on the result side while points keep coming
    quiet = 1'b0;
    setup(2, 1, 1, 4, 4, 8'h77, 8'h11, 8'h33);
    fill_stores();
    hold_reqs++;
    run_points(20);

    do begin
      phase($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
            $urandom_range(0, 6), $urandom_range(0, 6),
            {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))},
            {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))},
            {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))},
            $urandom_range(20, 40));
    end while (items < 650);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("grouped_conv2d_point: match");
    end else begin
      $display("grouped_conv2d_point: mismatch");
    end
    $finish;
  end

endmodule
